/* rtl/t1brc_pkg.sv */
// Shared types, codes and the CRC-16/X-25 byte update for the T=1 block receive checker.
package t1brc_pkg;

   localparam int unsigned INF_MAX = 254;

   localparam int unsigned CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_NAD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_INF_LEN  = 1'd1;

   localparam logic [7:0] NAD_RESET         = 8'hA5;
   localparam logic [7:0] MAX_INF_LEN_RESET = 8'(INF_MAX);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_XOUT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_LEN_BAD = 2'd1;
   localparam logic [1:0] STATUS_CRC_BAD = 2'd2;
   localparam logic [1:0] STATUS_S_UNSUP = 2'd3;

   localparam logic [1:0] KIND_I     = 2'd0;
   localparam logic [1:0] KIND_R     = 2'd1;
   localparam logic [1:0] KIND_S_REQ = 2'd2;
   localparam logic [1:0] KIND_S_RSP = 2'd3;

   localparam logic [4:0] S_TYPE_WTX = 5'h03;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       block_start;
   } req_type;

   typedef struct packed {
      logic [7:0] inf_byte;
      logic       inf_valid;
      logic       block_done;
      logic [1:0] status;
      logic       nad_mismatch;
      logic [1:0] block_kind;
      logic       seq_bit;
      logic       more_data;
      logic [1:0] r_error;
      logic [4:0] s_type;
      logic       wtx_request;
      logic [7:0] inf_length;
   } rsp_type;

   // Bytewise reflected CRC update, least significant bit first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/t1brc_parser.sv */
// Block framing state, CRC accumulation and PCB decode for one received byte per cycle while accept is high.
module t1brc_parser
   import t1brc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req,
   input  logic [7:0] expected_nad,
   input  logic [7:0] max_inf_len,
   output rsp_type    result
);

   logic [8:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  pcb_ff, pcb_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic        nad_bad_ff, nad_bad_in;

   logic [7:0]  limit;
   logic [8:0]  crc_pos;
   logic [15:0] crc_final;
   logic [15:0] crc_next;
   logic [7:0]  b;

   function automatic rsp_type report(input logic [7:0] pcb, input logic [7:0] len,
                                      input logic nad_bad, input logic [1:0] status);
      rsp_type r;
      logic [1:0] kind;
      r = '0;
      if (!pcb[7]) begin
         kind = KIND_I;
      end else if (!pcb[6]) begin
         kind = KIND_R;
      end else if (!pcb[5]) begin
         kind = KIND_S_REQ;
      end else begin
         kind = KIND_S_RSP;
      end
      r.block_done   = 1'b1;
      r.status       = status;
      r.nad_mismatch = nad_bad;
      r.block_kind   = kind;
      r.seq_bit      = (kind == KIND_I) ? pcb[6] : ((kind == KIND_R) ? pcb[4] : 1'b0);
      r.more_data    = (kind == KIND_I) ? pcb[5] : 1'b0;
      r.r_error      = (kind == KIND_R) ? pcb[1:0] : 2'b00;
      r.s_type       = (kind == KIND_S_REQ || kind == KIND_S_RSP) ? pcb[4:0] : 5'h00;
      r.wtx_request  = (kind == KIND_S_REQ) && (pcb[4:0] == S_TYPE_WTX);
      r.inf_length   = len;
      return r;
   endfunction

   assign b         = req.rx_byte;
   assign limit     = (max_inf_len < 8'(INF_MAX)) ? max_inf_len : 8'(INF_MAX);
   assign crc_pos   = {1'b0, len_ff} + 9'd3;
   assign crc_final = crc_ff ^ CRC_XOUT;
   assign crc_next  = crc_byte(crc_ff, b);

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      pcb_in     = pcb_ff;
      len_in     = len_ff;
      crc_lo_in  = crc_lo_ff;
      nad_bad_in = nad_bad_ff;
      result     = '0;
      if (accept) begin
         if (req.block_start) begin
            // A start byte always opens a new block, dropping any unfinished one.
            crc_in     = crc_byte(CRC_INIT, b);
            nad_bad_in = (b != expected_nad);
            pcb_in     = '0;
            len_in     = '0;
            crc_lo_in  = '0;
            pos_in     = 9'd1;
         end else if (pos_ff == 9'd0) begin
            pos_in = 9'd0;
         end else if (pos_ff == 9'd1) begin
            pcb_in = b;
            crc_in = crc_next;
            pos_in = 9'd2;
         end else if (pos_ff == 9'd2) begin
            len_in = b;
            if (b > limit) begin
               result = report(pcb_ff, b, nad_bad_ff, STATUS_LEN_BAD);
               pos_in = 9'd0;
            end else begin
               crc_in = crc_next;
               pos_in = 9'd3;
            end
         end else if (pos_ff < crc_pos) begin
            crc_in           = crc_next;
            result.inf_byte  = b;
            result.inf_valid = 1'b1;
            pos_in           = pos_ff + 9'd1;
         end else if (pos_ff == crc_pos) begin
            crc_lo_in = b;
            pos_in    = pos_ff + 9'd1;
         end else begin
            // A CRC error outranks an unsupported S request.
            if (crc_lo_ff != crc_final[7:0] || b != crc_final[15:8]) begin
               result = report(pcb_ff, len_ff, nad_bad_ff, STATUS_CRC_BAD);
            end else if (pcb_ff[7:5] == 3'b110 && pcb_ff[4:0] != S_TYPE_WTX) begin
               result = report(pcb_ff, len_ff, nad_bad_ff, STATUS_S_UNSUP);
            end else begin
               result = report(pcb_ff, len_ff, nad_bad_ff, STATUS_OK);
            end
            pos_in = 9'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= CRC_INIT;
         pcb_ff     <= '0;
         len_ff     <= '0;
         crc_lo_ff  <= '0;
         nad_bad_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         pcb_ff     <= pcb_in;
         len_ff     <= len_in;
         crc_lo_ff  <= crc_lo_in;
         nad_bad_ff <= nad_bad_in;
      end
   end

`ifndef SYNTH
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= crc_pos + 9'd1)
      else $error("byte position ran past the second CRC byte");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && result.block_done) |=> (pos_ff == 9'd0))
      else $error("block not closed after its report");

   a_inf_in_body: assert property (@(posedge clock) disable iff (reset)
      result.inf_valid |-> (accept && !req.block_start && pos_ff >= 9'd3 && pos_ff < crc_pos))
      else $error("information byte flagged outside the information field");
`endif

endmodule

/* rtl/t1brc_out_reg.sv */
// Result register that holds one finished result until the receiver takes it.
module t1brc_out_reg
   import t1brc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type result,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/t1_block_receive_checker_core.sv */
// Top level of the T=1 block receive checker: register port, byte parser and result register.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall  req_data (rx_byte, block_start)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (one result per received byte)
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// The result of each received byte appears in the cycle after the byte is accepted.
// The CRC update and PCB decode sit between the state registers and the result register.
// One byte per cycle is sustained while the receiver keeps rsp_stall low.
// A transfer is taken while a waiting result leaves in the same cycle.
// Reset is synchronous: the checker waits for a start byte and the registers take
// their default values, except the result data register, which is not reset.
module t1_block_receive_checker_core
   import t1brc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   logic [7:0] expected_nad_ff, expected_nad_in;
   logic [7:0] max_inf_len_ff, max_inf_len_in;
   logic       accept;
   rsp_type    result;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      expected_nad_in = expected_nad_ff;
      max_inf_len_in  = max_inf_len_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EXPECTED_NAD: expected_nad_in = csr_wdata;
            CSR_MAX_INF_LEN:  max_inf_len_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_nad_ff <= NAD_RESET;
         max_inf_len_ff  <= MAX_INF_LEN_RESET;
      end else begin
         expected_nad_ff <= expected_nad_in;
         max_inf_len_ff  <= max_inf_len_in;
      end
   end

   t1brc_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req          (req_data),
      .expected_nad (expected_nad_ff),
      .max_inf_len  (max_inf_len_ff),
      .result       (result)
   );

   t1brc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
